// ===== rtl/mwo_pkg.sv =====
// Shared types, constants, microprogram and sine table builder for the wave oscillator.
package mwo_pkg;

   localparam int PHASE_BITS_DEFAULT       = 32;
   localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int ONE_Q15       = 32768;
   localparam int NOISE_LEVELS  = 2001;
   localparam logic [15:0] NOISE_SEED = 16'hACE1;
   localparam logic [15:0] NOISE_TAPS = 16'hB400;
   // floor(t / 125) = (t * NOISE_RECIP) >> NOISE_SHIFT, exact for t below 2^18
   localparam int NOISE_RECIP   = 268436;
   localparam int NOISE_SHIFT   = 25;
   localparam int NOISE_Q_BITS  = 11;

   // waveform codes
   localparam logic [2:0] WAVE_SINE     = 3'd0;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
   localparam logic [2:0] WAVE_SQUARE   = 3'd2;
   localparam logic [2:0] WAVE_SAW      = 3'd3;
   localparam logic [2:0] WAVE_NOISE    = 3'd4;
   localparam logic [2:0] WAVE_SILENT   = 3'd5;

   // register indexes, byte address = 4 * index
   localparam logic [2:0] REG_WAVEFORM      = 3'd0;
   localparam logic [2:0] REG_CARRIER_STEP  = 3'd1;
   localparam logic [2:0] REG_VIBRATO_STEP  = 3'd2;
   localparam logic [2:0] REG_VIBRATO_DEPTH = 3'd3;
   localparam logic [2:0] REG_DUTY_STEP     = 3'd4;
   localparam logic [2:0] REG_DUTY_DEPTH    = 3'd5;
   localparam logic [2:0] REG_TREMOLO_STEP  = 3'd6;
   localparam logic [2:0] REG_TREMOLO_DEPTH = 3'd7;

   localparam int UPC_BITS = 5;
   typedef logic [UPC_BITS-1:0] upc_type;

   localparam upc_type PC_IDLE      = 5'd0;
   localparam upc_type PC_ROM_VIB   = 5'd1;
   localparam upc_type PC_ROM_DUTY  = 5'd2;
   localparam upc_type PC_PHASE     = 5'd3;
   localparam upc_type PC_THRESH    = 5'd4;
   localparam upc_type PC_GAIN      = 5'd5;
   localparam upc_type PC_LEVEL     = 5'd6;
   localparam upc_type PC_ENV       = 5'd7;
   localparam upc_type PC_MOD_LOAD  = 5'd8;
   localparam upc_type PC_MOD_FIRST = 5'd9;
   localparam upc_type PC_MOD_LAST  = 5'd14;
   localparam upc_type PC_NOISE_MUL = 5'd15;
   localparam upc_type PC_NOISE_WAV = 5'd16;
   localparam upc_type PC_OUT_MUL   = 5'd17;
   localparam upc_type PC_WRITE     = 5'd18;

   typedef enum logic [2:0] {
      ROM_NONE, ROM_VIB, ROM_DUTY, ROM_TREM, ROM_CARR
   } rom_src_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_VIB, MUL_DUTY, MUL_TREM, MUL_LEVEL, MUL_NOISE, MUL_OUT
   } mul_src_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_PHASE, OP_THRESH, OP_GAIN_WAVE, OP_ENV, OP_MOD_LOAD, OP_MOD_SUB,
      OP_NOISE_WAVE, OP_WRITE
   } op_type;

   typedef enum logic [1:0] {
      JMP_NEXT, JMP_ACCEPT, JMP_TONE, JMP_OUT_FREE
   } jump_type;

   typedef struct packed {
      rom_src_type rom_src;
      mul_src_type mul_src;
      op_type      op;
      logic [2:0]  sub_shift;
      jump_type    jump;
      upc_type     target;
   } ucode_type;

   // microprogram ROM
   function automatic ucode_type ucode_word(input upc_type pc);
      ucode_type w;
      begin
         w.rom_src   = ROM_NONE;
         w.mul_src   = MUL_NONE;
         w.op        = OP_NONE;
         w.sub_shift = 3'd0;
         w.jump      = JMP_NEXT;
         w.target    = PC_IDLE;
         unique case (pc) inside
            PC_IDLE:     w.jump = JMP_ACCEPT;
            PC_ROM_VIB:  w.rom_src = ROM_VIB;
            PC_ROM_DUTY: begin
               w.rom_src = ROM_DUTY;
               w.mul_src = MUL_VIB;
            end
            PC_PHASE: begin
               w.rom_src = ROM_TREM;
               w.mul_src = MUL_DUTY;
               w.op      = OP_PHASE;
            end
            PC_THRESH: begin
               w.rom_src = ROM_CARR;
               w.mul_src = MUL_TREM;
               w.op      = OP_THRESH;
            end
            PC_GAIN:     w.op = OP_GAIN_WAVE;
            PC_LEVEL:    w.mul_src = MUL_LEVEL;
            PC_ENV: begin
               w.op     = OP_ENV;
               w.jump   = JMP_TONE;
               w.target = PC_OUT_MUL;
            end
            PC_MOD_LOAD: w.op = OP_MOD_LOAD;
            [PC_MOD_FIRST:PC_MOD_LAST]: begin
               w.op        = OP_MOD_SUB;
               w.sub_shift = 3'(PC_MOD_LAST - pc);
            end
            PC_NOISE_MUL: w.mul_src = MUL_NOISE;
            PC_NOISE_WAV: w.op = OP_NOISE_WAVE;
            PC_OUT_MUL:   w.mul_src = MUL_OUT;
            PC_WRITE: begin
               w.op     = OP_WRITE;
               w.jump   = JMP_OUT_FREE;
               w.target = PC_IDLE;
            end
            default: begin
               w.jump   = JMP_OUT_FREE;
               w.target = PC_IDLE;
            end
         endcase
         return w;
      end
   endfunction

   // quarter-wave sine entry r of (2^shift)+1, Q1.15 magnitude; elaboration only
   function automatic logic [14:0] sine_entry(input int unsigned r, input int unsigned shift);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      longint q;
      begin
         x    = (longint'(r) * HALF_PI_Q30) >> shift;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         term = ((term * x2) >> 30) / 6;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 20;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 42;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 72;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 110;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 156;
         sum  = sum + longint'(term);
         if (sum < 0) sum = 0;
         q = (sum + 16384) >>> 15;
         if (q > 32767) q = 32767;
         return 15'(q);
      end
   endfunction

endpackage

// ===== rtl/modulated_wave_oscillator_unit.sv =====
// Wave oscillator with vibrato, duty and tremolo LFOs, run by a microcoded sequencer.
//
// Input channel req_: one word per sample tick, an envelope level and a restart
// flag; restart zeroes the carrier and the three LFO phases before the sample.
// Result channel rsp_: one signed sample per accepted word, in order.
// Registers sit on the APB port at byte address 4*index; pready is always high.
// Each word runs a microprogram over one shared 20x20 multiplier and the sine
// table: three LFO lookups, carrier lookup, five scaled products, one more for
// noise. Steps: LFO lookups, phase, threshold, gain and wave, level, envelope,
// output product, then a write step that loads the result register; noise adds
// six conditional subtract steps for mod 2001 plus a reciprocal multiply before
// the output product. A new word is taken only in the idle step; req_stall is
// high while the microprogram runs.
// The result register lets the next word enter while a sample waits; if rsp_stall
// still holds the old sample when the next one is ready, the final step waits.
// Reset clears the configuration registers and phases, seeds the noise LFSR
// with 0xACE1 and leaves no result pending.
module modulated_wave_oscillator_unit #(
   parameter int PHASE_BITS       = mwo_pkg::PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_DEPTH = mwo_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [14:0]        req_envelope_level,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample_out,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int IDX_BITS  = $clog2(SINE_TABLE_DEPTH);
   localparam int ADDR_BITS = IDX_BITS - 1;
   localparam int QUARTER   = SINE_TABLE_DEPTH / 4;

   // configuration
   logic [2:0]  waveform_ff;
   logic [31:0] carrier_step_ff, vibrato_step_ff, duty_step_ff, tremolo_step_ff;
   logic [15:0] vibrato_depth_ff, duty_depth_ff, tremolo_depth_ff;

   // state
   logic [PHASE_BITS-1:0] carrier_ff, vibrato_ff, duty_ff, tremolo_ff;
   logic [PHASE_BITS-1:0] carrier_in, vibrato_in, duty_in, tremolo_in;
   logic [15:0] noise_ff, noise_in;

   // sequencer
   mwo_pkg::upc_type   pc_ff, pc_in;
   mwo_pkg::ucode_type uc;

   // datapath
   logic [14:0]        level_ff;
   logic signed [15:0] rom_ff, rom_in;
   logic signed [39:0] prod_ff, prod_in;
   logic [15:0]        p_ff, p_in;
   logic [16:0]        thr_ff, thr_in;
   logic signed [16:0] gain_ff, gain_in;
   logic signed [16:0] wave_ff, wave_in;
   logic signed [16:0] env_ff, env_in;
   logic [15:0]        mod_ff, mod_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic req_accept, out_free, write_fire, cfg_write;

   // sine table and lookup
   logic [14:0]          sine_rom [QUARTER+1];
   logic [15:0]          rom_phase;
   logic [IDX_BITS-1:0]  sine_idx;
   logic [ADDR_BITS-1:0] sine_addr;
   logic signed [15:0]   sine_pos, sine_val;

   // multiplier and rounding
   logic signed [19:0] mul_a, mul_b;
   logic signed [39:0] prod_rnd;
   logic signed [17:0] rnd18, thr_sum, gain_sum, tri_val;
   logic signed [17:0] p_s;
   logic [15:0]        duty_sat, trem_sat, mod_sub;
   logic [17:0]        noise_t, noise_wave;

   for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_sine
      assign sine_rom[gi] = mwo_pkg::sine_entry(gi, IDX_BITS - 2);
   end

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (pc_ff != mwo_pkg::PC_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign uc         = mwo_pkg::ucode_word(pc_ff);
   assign write_fire = (uc.op == mwo_pkg::OP_WRITE) && out_free;
   assign cfg_write  = psel && penable && pwrite;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign pready         = 1'b1;

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff      <= '0;
         carrier_step_ff  <= '0;
         vibrato_step_ff  <= '0;
         vibrato_depth_ff <= '0;
         duty_step_ff     <= '0;
         duty_depth_ff    <= '0;
         tremolo_step_ff  <= '0;
         tremolo_depth_ff <= '0;
      end else if (cfg_write) begin
         unique case (paddr[4:2])
            mwo_pkg::REG_WAVEFORM:      waveform_ff      <= pwdata[2:0];
            mwo_pkg::REG_CARRIER_STEP:  carrier_step_ff  <= pwdata;
            mwo_pkg::REG_VIBRATO_STEP:  vibrato_step_ff  <= pwdata;
            mwo_pkg::REG_VIBRATO_DEPTH: vibrato_depth_ff <= pwdata[15:0];
            mwo_pkg::REG_DUTY_STEP:     duty_step_ff     <= pwdata;
            mwo_pkg::REG_DUTY_DEPTH:    duty_depth_ff    <= pwdata[15:0];
            mwo_pkg::REG_TREMOLO_STEP:  tremolo_step_ff  <= pwdata;
            mwo_pkg::REG_TREMOLO_DEPTH: tremolo_depth_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         mwo_pkg::REG_WAVEFORM:      prdata = {29'd0, waveform_ff};
         mwo_pkg::REG_CARRIER_STEP:  prdata = carrier_step_ff;
         mwo_pkg::REG_VIBRATO_STEP:  prdata = vibrato_step_ff;
         mwo_pkg::REG_VIBRATO_DEPTH: prdata = {16'd0, vibrato_depth_ff};
         mwo_pkg::REG_DUTY_STEP:     prdata = duty_step_ff;
         mwo_pkg::REG_DUTY_DEPTH:    prdata = {16'd0, duty_depth_ff};
         mwo_pkg::REG_TREMOLO_STEP:  prdata = tremolo_step_ff;
         mwo_pkg::REG_TREMOLO_DEPTH: prdata = {16'd0, tremolo_depth_ff};
         default:                    prdata = '0;
      endcase
   end

   // sine lookup: quarter table mirrored on odd quadrants, negated when the phase MSB is set
   always_comb begin
      unique case (uc.rom_src)
         mwo_pkg::ROM_VIB:  rom_phase = vibrato_ff[PHASE_BITS-1 -: 16];
         mwo_pkg::ROM_DUTY: rom_phase = duty_ff[PHASE_BITS-1 -: 16];
         mwo_pkg::ROM_TREM: rom_phase = tremolo_ff[PHASE_BITS-1 -: 16];
         mwo_pkg::ROM_CARR: rom_phase = p_ff;
         default:           rom_phase = '0;
      endcase
      sine_idx = rom_phase[15 -: IDX_BITS];
      if (sine_idx[IDX_BITS-2])
         sine_addr = ADDR_BITS'(QUARTER) - {1'b0, sine_idx[IDX_BITS-3:0]};
      else
         sine_addr = {1'b0, sine_idx[IDX_BITS-3:0]};
      sine_pos = {1'b0, sine_rom[sine_addr]};
      sine_val = sine_idx[IDX_BITS-1] ? -sine_pos : sine_pos;
      rom_in   = (uc.rom_src != mwo_pkg::ROM_NONE) ? sine_val : rom_ff;
   end

   // shared multiplier
   always_comb begin
      duty_sat = (duty_depth_ff > 16'(mwo_pkg::ONE_Q15)) ? 16'(mwo_pkg::ONE_Q15)
                                                           : duty_depth_ff;
      trem_sat = (tremolo_depth_ff > 16'(mwo_pkg::ONE_Q15)) ? 16'(mwo_pkg::ONE_Q15)
                                                              : tremolo_depth_ff;
      noise_t  = 18'(mod_ff[10:0]) * 18'd96 + 18'd62;
      mul_a    = '0;
      mul_b    = '0;
      unique case (uc.mul_src)
         mwo_pkg::MUL_VIB: begin
            mul_a = {4'd0, vibrato_depth_ff};
            mul_b = 20'(rom_ff);
         end
         mwo_pkg::MUL_DUTY: begin
            mul_a = {4'd0, duty_sat};
            mul_b = 20'(rom_ff);
         end
         mwo_pkg::MUL_TREM: begin
            mul_a = {4'd0, trem_sat};
            mul_b = 20'sd32768 - 20'(rom_ff);
         end
         mwo_pkg::MUL_LEVEL: begin
            mul_a = {5'd0, level_ff};
            mul_b = 20'(gain_ff);
         end
         mwo_pkg::MUL_NOISE: begin
            mul_a = {2'd0, noise_t};
            mul_b = 20'(mwo_pkg::NOISE_RECIP);
         end
         mwo_pkg::MUL_OUT: begin
            mul_a = 20'(env_ff);
            mul_b = 20'(wave_ff);
         end
         default: ;
      endcase
      prod_in = (uc.mul_src != mwo_pkg::MUL_NONE) ? 40'(mul_a) * 40'(mul_b) : prod_ff;
   end

   // datapath ops
   always_comb begin
      prod_rnd = prod_ff + 40'sd16384;
      rnd18    = $signed(prod_rnd[32:15]);
      thr_sum  = 18'sd32768 + rnd18;
      gain_sum = 18'sd32768 - rnd18;
      p_s      = {2'b00, p_ff};

      if (p_ff < 16'd16384)
         tri_val = p_s <<< 1;
      else if (p_ff < 16'd49152)
         tri_val = 18'sd32768 - ((p_s - 18'sd16384) <<< 1);
      else
         tri_val = ((p_s - 18'sd49152) <<< 1) - 18'sd32768;

      mod_sub    = 16'(mwo_pkg::NOISE_LEVELS << uc.sub_shift);
      noise_wave = {2'b00, mod_ff[10:0], 5'd0}
                 + {7'd0, prod_ff[mwo_pkg::NOISE_SHIFT + mwo_pkg::NOISE_Q_BITS - 1 :
                                  mwo_pkg::NOISE_SHIFT]}
                 - 18'd32768;

      p_in     = p_ff;
      thr_in   = thr_ff;
      gain_in  = gain_ff;
      wave_in  = wave_ff;
      env_in   = env_ff;
      mod_in   = mod_ff;
      noise_in = noise_ff;

      case (uc.op)
         mwo_pkg::OP_PHASE:  p_in = carrier_ff[PHASE_BITS-1 -: 16] + prod_rnd[30:15];
         mwo_pkg::OP_THRESH: thr_in = thr_sum[16:0];
         mwo_pkg::OP_GAIN_WAVE: begin
            gain_in = gain_sum[16:0];
            case (waveform_ff)
               mwo_pkg::WAVE_SINE:     wave_in = 17'(rom_ff);
               mwo_pkg::WAVE_TRIANGLE: wave_in = tri_val[16:0];
               mwo_pkg::WAVE_SQUARE:
                  wave_in = ({1'b0, p_ff} < thr_ff) ? 17'sd32768 : -17'sd32768;
               mwo_pkg::WAVE_SAW:      wave_in = 17'($signed(p_ff));
               default:                wave_in = '0;
            endcase
         end
         mwo_pkg::OP_ENV:      env_in = rnd18[16:0];
         mwo_pkg::OP_MOD_LOAD: mod_in = noise_ff;
         mwo_pkg::OP_MOD_SUB:  mod_in = (mod_ff >= mod_sub) ? mod_ff - mod_sub : mod_ff;
         mwo_pkg::OP_NOISE_WAVE: begin
            wave_in  = noise_wave[16:0];
            noise_in = {1'b0, noise_ff[15:1]} ^ (noise_ff[0] ? mwo_pkg::NOISE_TAPS : 16'h0);
         end
         default: ;
      endcase

      if (rnd18 > 18'sd32767)
         rsp_sample_in = 16'sd32767;
      else if (rnd18 < -18'sd32767)
         rsp_sample_in = -16'sd32767;
      else
         rsp_sample_in = rnd18[15:0];

      rsp_valid_in = write_fire || (rsp_valid_ff && rsp_stall);
   end

   // phase accumulators: cleared on restart, advanced when the sample is written to the result register
   always_comb begin
      carrier_in = carrier_ff;
      vibrato_in = vibrato_ff;
      duty_in    = duty_ff;
      tremolo_in = tremolo_ff;
      if (req_accept && req_restart) begin
         carrier_in = '0;
         vibrato_in = '0;
         duty_in    = '0;
         tremolo_in = '0;
      end
      if (write_fire) begin
         carrier_in = carrier_ff + PHASE_BITS'(carrier_step_ff);
         vibrato_in = vibrato_ff + PHASE_BITS'(vibrato_step_ff);
         duty_in    = duty_ff + PHASE_BITS'(duty_step_ff);
         tremolo_in = tremolo_ff + PHASE_BITS'(tremolo_step_ff);
      end
   end

   // step counter
   always_comb begin
      unique case (uc.jump)
         mwo_pkg::JMP_NEXT:     pc_in = pc_ff + 1'b1;
         mwo_pkg::JMP_ACCEPT:   pc_in = req_accept ? pc_ff + 1'b1 : pc_ff;
         mwo_pkg::JMP_TONE:
            pc_in = (waveform_ff != mwo_pkg::WAVE_NOISE) ? uc.target : pc_ff + 1'b1;
         mwo_pkg::JMP_OUT_FREE: pc_in = out_free ? uc.target : pc_ff;
         default:               pc_in = mwo_pkg::PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= mwo_pkg::PC_IDLE;
         rsp_valid_ff <= 1'b0;
         carrier_ff   <= '0;
         vibrato_ff   <= '0;
         duty_ff      <= '0;
         tremolo_ff   <= '0;
         noise_ff     <= mwo_pkg::NOISE_SEED;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         carrier_ff   <= carrier_in;
         vibrato_ff   <= vibrato_in;
         duty_ff      <= duty_in;
         tremolo_ff   <= tremolo_in;
         noise_ff     <= noise_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) level_ff <= req_envelope_level;
      rom_ff  <= rom_in;
      prod_ff <= prod_in;
      p_ff    <= p_in;
      thr_ff  <= thr_in;
      gain_ff <= gain_in;
      wave_ff <= wave_in;
      env_ff  <= env_in;
      mod_ff  <= mod_in;
      if (write_fire) rsp_sample_ff <= rsp_sample_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> pc_ff == mwo_pkg::PC_ROM_VIB)
      else $error("accepted word did not start the microprogram");

   a_mod_reduced: assert property (@(posedge clock) disable iff (reset)
      pc_ff == mwo_pkg::PC_NOISE_MUL |-> mod_ff < 16'(mwo_pkg::NOISE_LEVELS))
      else $error("noise value not reduced below 2001");

   a_lfsr_alive: assert property (@(posedge clock) disable iff (reset)
      noise_ff != 16'h0)
      else $error("noise LFSR locked at zero");

   a_sample_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sample_ff != 16'h8000)
      else $error("sample not clamped");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= mwo_pkg::PC_WRITE)
      else $error("step counter past end of program");

endmodule

// ===== sim/oscillator_checker.sv =====
// Sample predictor and in-order comparison for the modulated wave oscillator.
module oscillator_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [14:0]        req_envelope_level,
   input  logic               req_restart,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_sample_out,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int                 samples_owed,
   output int                 failure_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64_type;

   localparam u64_type TABLE_DEPTH = u64_type'(mwo_pkg::SINE_TABLE_DEPTH_DEFAULT);

   // register copies
   logic [2:0]  wave_sel;
   logic [31:0] carrier_inc, vib_inc, duty_inc, trem_inc;
   logic [15:0] vib_depth, duty_depth, trem_depth;

   // oscillator state
   logic [31:0] carrier_ph, vib_ph, duty_ph, trem_ph;
   logic [15:0] lfsr;

   logic signed [15:0] expected_samples[$];
   logic signed [15:0] want;
   int owed_q = 0;
   int fail_q = 0;

   assign samples_owed  = owed_q;
   assign failure_count = fail_q;

   // round half up: floor((2a+b)/(2b))
   function automatic longint round_div(input longint a, input longint b);
      longint n;
      longint d;
      n = 2 * a + b;
      d = 2 * b;
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   // table sine of a 16-bit phase, Q1.15, quarter-wave Taylor series in Q30
   function automatic longint sine_q15_of(input logic [15:0] p16);
      u64_type idx, u, quad, r, x, x2, term;
      longint acc;
      longint q;
      int k;
      idx  = (u64_type'(p16) * TABLE_DEPTH) >> 16;
      u    = idx * 4;
      quad = (u / TABLE_DEPTH) & 3;
      r    = u % TABLE_DEPTH;
      if (quad[0]) r = TABLE_DEPTH - r;
      x    = r * mwo_pkg::HALF_PI_Q30 / TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (k = 1; k <= 6; k++) begin
         term = ((term * x2) >> 30) / u64_type'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      q = (acc + 16384) >>> 15;
      if (q > 32767) q = 32767;
      return (quad >= 2) ? -q : q;
   endfunction

   function automatic logic signed [15:0] predict_sample(input logic [14:0] level,
                                                         input logic restart);
      longint sv, sd, st, off, thr, dd, td, gain, env, wave, smp, n;
      logic [31:0] cp;
      logic [15:0] p;
      if (restart) begin
         carrier_ph = '0;
         vib_ph     = '0;
         duty_ph    = '0;
         trem_ph    = '0;
      end
      sv = sine_q15_of(vib_ph[31:16]);
      sd = sine_q15_of(duty_ph[31:16]);
      st = sine_q15_of(trem_ph[31:16]);

      off = round_div(longint'(vib_depth) * sv, mwo_pkg::ONE_Q15);
      cp  = carrier_ph + 32'(off * 65536);
      p   = cp[31:16];

      dd = longint'(duty_depth);
      if (dd > mwo_pkg::ONE_Q15) dd = mwo_pkg::ONE_Q15;
      thr = mwo_pkg::ONE_Q15 + round_div(dd * sd, mwo_pkg::ONE_Q15);

      td = longint'(trem_depth);
      if (td > mwo_pkg::ONE_Q15) td = mwo_pkg::ONE_Q15;
      gain = mwo_pkg::ONE_Q15 - round_div(td * (mwo_pkg::ONE_Q15 - st), mwo_pkg::ONE_Q15);
      env  = round_div(longint'(level) * gain, mwo_pkg::ONE_Q15);

      case (wave_sel)
         mwo_pkg::WAVE_SINE: wave = sine_q15_of(p);
         mwo_pkg::WAVE_TRIANGLE: begin
            if (p < 16'd16384) wave = longint'(p) * 2;
            else if (p < 16'd49152)
               wave = mwo_pkg::ONE_Q15 - (longint'(p) - 16384) * 2;
            else wave = (longint'(p) - 49152) * 2 - mwo_pkg::ONE_Q15;
         end
         mwo_pkg::WAVE_SQUARE:
            wave = (longint'(p) < thr) ? mwo_pkg::ONE_Q15 : -mwo_pkg::ONE_Q15;
         mwo_pkg::WAVE_SAW: wave = longint'(signed'(p));
         mwo_pkg::WAVE_NOISE: begin
            n    = (longint'(lfsr) % mwo_pkg::NOISE_LEVELS) - 1000;
            wave = round_div(n * mwo_pkg::ONE_Q15, 1000);
            // Galois LFSR steps only on noise ticks, after use
            lfsr = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? mwo_pkg::NOISE_TAPS : 16'h0000);
         end
         default: wave = 0;
      endcase

      smp = round_div(env * wave, mwo_pkg::ONE_Q15);
      if (smp > 32767) smp = 32767;
      if (smp < -32767) smp = -32767;

      carrier_ph = carrier_ph + carrier_inc;
      vib_ph     = vib_ph + vib_inc;
      duty_ph    = duty_ph + duty_inc;
      trem_ph    = trem_ph + trem_inc;
      return 16'(smp);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         wave_sel    = mwo_pkg::WAVE_SINE;
         carrier_inc = '0;
         vib_inc     = '0;
         duty_inc    = '0;
         trem_inc    = '0;
         vib_depth   = '0;
         duty_depth  = '0;
         trem_depth  = '0;
         carrier_ph  = '0;
         vib_ph      = '0;
         duty_ph     = '0;
         trem_ph     = '0;
         lfsr        = mwo_pkg::NOISE_SEED;
         expected_samples.delete();
         owed_q <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               mwo_pkg::REG_WAVEFORM:      wave_sel    = pwdata[2:0];
               mwo_pkg::REG_CARRIER_STEP:  carrier_inc = pwdata;
               mwo_pkg::REG_VIBRATO_STEP:  vib_inc     = pwdata;
               mwo_pkg::REG_VIBRATO_DEPTH: vib_depth   = pwdata[15:0];
               mwo_pkg::REG_DUTY_STEP:     duty_inc    = pwdata;
               mwo_pkg::REG_DUTY_DEPTH:    duty_depth  = pwdata[15:0];
               mwo_pkg::REG_TREMOLO_STEP:  trem_inc    = pwdata;
               mwo_pkg::REG_TREMOLO_DEPTH: trem_depth  = pwdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_samples.push_back(predict_sample(req_envelope_level, req_restart));
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               fail_q = fail_q + 1;
               $error("sample_out: expected nothing, got %0d", rsp_sample_out);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want) begin
                  fail_q = fail_q + 1;
                  $error("sample_out: expected %0d, got %0d", want, rsp_sample_out);
               end
            end
         end
         owed_q <= expected_samples.size();
      end
   end

endmodule

// ===== sim/testbench.sv =====
// Top level: clock, reset, register setup and word stimulus around the oscillator.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [14:0]        req_envelope_level = '0;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample_out;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   int   samples_owed;
   int   failure_count;
   int   cycle_count = 0;
   logic quiet = 1'b0;

   always #5 clock = ~clock;

   modulated_wave_oscillator_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_envelope_level (req_envelope_level),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   oscillator_checker sample_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_envelope_level (req_envelope_level),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .pready             (pready),
      .samples_owed       (samples_owed),
      .failure_count      (failure_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver backpressure
   always @(posedge clock)
      rsp_stall <= !quiet && ($urandom_range(99) < 16);

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [2:0] wave, input logic [31:0] carrier,
                                input logic [31:0] vib_step, input logic [15:0] vib_depth,
                                input logic [31:0] duty_step, input logic [15:0] duty_depth,
                                input logic [31:0] trem_step, input logic [15:0] trem_depth);
      csr_write(mwo_pkg::REG_WAVEFORM, 32'(wave));
      csr_write(mwo_pkg::REG_CARRIER_STEP, carrier);
      csr_write(mwo_pkg::REG_VIBRATO_STEP, vib_step);
      csr_write(mwo_pkg::REG_VIBRATO_DEPTH, 32'(vib_depth));
      csr_write(mwo_pkg::REG_DUTY_STEP, duty_step);
      csr_write(mwo_pkg::REG_DUTY_DEPTH, 32'(duty_depth));
      csr_write(mwo_pkg::REG_TREMOLO_STEP, trem_step);
      csr_write(mwo_pkg::REG_TREMOLO_DEPTH, 32'(trem_depth));
   endtask

   // stop sending and wait for every predicted sample to come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (samples_owed != 0);
   endtask

   // valid stays high on return; the caller lowers it or sends the next word
   task automatic send_word(input logic [14:0] level, input logic restart);
      if (!quiet && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_envelope_level <= level;
      req_restart        <= restart;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom;
         default: return $urandom_range(0, 32'h00FF_FFFF);
      endcase
   endfunction

   function automatic logic [15:0] pick_depth();
      case ($urandom_range(0, 4))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'hFFFF;
         3: return 16'($urandom_range(0, 32768));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [14:0] pick_level();
      case ($urandom_range(0, 7))
         0: return 15'd0;
         1: return 15'h7FFF;
         default: return 15'($urandom);
      endcase
   endfunction

   initial begin
      int phase;
      int count;
      int w;
      logic [2:0] wave;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every waveform code, including the two undefined ones, at extreme levels
      // with saturating depths alternating between duty and tremolo
      for (w = 0; w < 8; w++) begin
         load_settings(3'(w), 32'h0900_0000, 32'h1000_0000, 16'hFFFF, 32'h2000_0000,
                       (w % 2 == 0) ? 16'hFFFF : 16'd32768, 32'h0800_0000,
                       (w % 2 == 1) ? 16'hFFFF : 16'd32768);
         send_word(15'h7FFF, 1'b1);
         send_word(15'd0, 1'b0);
         send_word(15'h7FFF, 1'b0);
         drain();
      end

      for (phase = 0; phase < 22; phase++) begin
         quiet <= (phase >= 6 && phase < 10);
         case ($urandom_range(0, 9))
            0: wave = mwo_pkg::WAVE_SILENT;
            1: wave = 3'($urandom_range(6, 7));
            2, 3: wave = mwo_pkg::WAVE_NOISE;
            default: wave = 3'($urandom_range(0, 3));
         endcase
         load_settings(wave, pick_step(), pick_step(), pick_depth(), pick_step(),
                       pick_depth(), pick_step(), pick_depth());
         count = $urandom_range(20, 40);
         repeat (count)
            send_word(pick_level(), $urandom_range(15) == 0);
         drain();
      end

      quiet <= 1'b0;
      repeat (40) @(posedge clock);
      if (failure_count == 0 && samples_owed == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
